// ===== hdl/lqrsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lqrsf_pkg
// Shared types for the state-feedback gain block: command and result items.
// ----------------------------------------------------------------------------
package lqrsf_pkg;

    // item kinds carried in the opcode field
    typedef enum logic [1:0] {
        OP_LOAD_GAIN = 2'd0,
        OP_LOAD_REF  = 2'd1,
        OP_LOAD_TRIM = 2'd2,
        OP_STATE     = 2'd3
    } lqrsf_op_t;

    // one input item
    typedef struct packed {
        lqrsf_op_t          opcode;
        logic [1:0]         row;
        logic [3:0]         column;
        logic signed [31:0] value;
        logic               frame_ok;
        logic               last;
    } lqrsf_cmd_t;

    // one result item
    typedef struct packed {
        logic [1:0]         slot;
        logic signed [31:0] torque;
        logic               valid_res;
        logic               final_res;
    } lqrsf_res_t;

endpackage

// ===== hdl/lqrsf_gain_mem.sv =====
// ----------------------------------------------------------------------------
// lqrsf_gain_mem
// Gain coefficient store: one write port, one registered read port. Entries
// carry a valid bit cleared by reset so an unwritten entry reads as zero.
// ----------------------------------------------------------------------------
module lqrsf_gain_mem #(
    parameter int DEPTH = 40,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [31:0]   wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic signed [31:0]   rd_data
);

    logic signed [31:0] mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    logic signed [31:0] rd_data_reg;
    logic               rd_vld_reg;

    // storage array and raw read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-entry valid bits and the valid bit of the read entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : 32'sd0;

endmodule

// ===== hdl/lqr_state_feedback.sv =====
// ----------------------------------------------------------------------------
// lqr_state_feedback
// Fixed-point state-feedback control law u = u0 - K * (x - x_ref).
// ----------------------------------------------------------------------------
// Usage:
//   An item on cmd is taken at a clock edge with start high and busy low.
//   Load items (gain, reference, trim) complete in the accept cycle and leave
//   busy low. A state element holds busy while its gain row entries are read
//   from the gain memory one per cycle and run through a single 32x32
//   multiplier and accumulator stage. An element whose column is out of
//   range or whose difference overflows skips the multiply pass.
//   The element marked last adds an emit phase: results appear on result,
//   one per cycle in slot order, each with strobe high for a single cycle,
//   once the multiply pass has ended. The receiver cannot stall; it must
//   take each result in its strobe cycle.
//   A bad frame (missing frame_ok or any 32-bit overflow) gives all-zero
//   torques with valid_res low. After the final result the accumulators and
//   the bad-frame flag are cleared.
//   Reset clears gain, reference and trim tables (gain entries read as zero
//   until written), the accumulators and the sequencer, with no sweep.
// ----------------------------------------------------------------------------
module lqr_state_feedback
    import lqrsf_pkg::*;
#(
    parameter int STATE_COUNT  = 10,
    parameter int OUTPUT_COUNT = 4,
    parameter int FRAC_BITS    = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  lqrsf_cmd_t cmd,
    output logic       strobe,
    output lqrsf_res_t result
);

    localparam int GAIN_DEPTH = OUTPUT_COUNT * STATE_COUNT;
    localparam int GAIN_AW    = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;
    localparam int REF_AW     = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int ROW_W      = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
    localparam logic [ROW_W-1:0]   ROW_LAST = ROW_W'(OUTPUT_COUNT - 1);
    localparam logic [GAIN_AW-1:0] ROW_STEP = GAIN_AW'(STATE_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } fsm_t;

    fsm_t               state_reg;
    logic signed [31:0] ref_reg  [STATE_COUNT];
    logic signed [31:0] trim_reg [OUTPUT_COUNT];
    logic signed [31:0] acc_reg  [OUTPUT_COUNT];
    logic               bad_reg;
    logic               last_reg;
    logic               issuing_reg;
    logic [ROW_W-1:0]   issue_row_reg;
    logic [GAIN_AW-1:0] issue_addr_reg;
    logic               s1_vld_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s2_vld_reg;
    logic [ROW_W-1:0]   s2_row_reg;
    logic [ROW_W-1:0]   emit_row_reg;
    logic signed [31:0] diff_reg;
    logic signed [63:0] prod_reg;
    logic               strobe_reg;
    lqrsf_res_t         result_reg;

    logic               accept;
    logic               row_ok;
    logic               col_ok;
    logic signed [31:0] ref_sel;
    logic [32:0]        diff_wide;
    logic               diff_fits;
    logic               gain_wr_en;
    logic [GAIN_AW-1:0] gain_wr_addr;
    logic               gain_rd_en;
    logic signed [31:0] gain_rd_data;
    logic signed [63:0] prod_comb;
    logic signed [63:0] prod_shift;
    logic [63:0]        sum_wide;
    logic               sum_fits;
    logic               out_ovf;
    logic               emit_bad;
    logic [32:0]        torque_wide;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign strobe = strobe_reg;
    assign result = result_reg;

    // address range checks for the incoming item
    assign row_ok = (32'(cmd.row) < 32'(OUTPUT_COUNT));
    assign col_ok = (32'(cmd.column) < 32'(STATE_COUNT));

    // element minus reference, checked against the 32-bit range
    assign ref_sel   = col_ok ? ref_reg[REF_AW'(cmd.column)] : 32'sd0;
    assign diff_wide = {cmd.value[31], cmd.value} - {ref_sel[31], ref_sel};
    assign diff_fits = (diff_wide[32] == diff_wide[31]);

    // gain memory write on gain load items
    assign gain_wr_en   = accept && (cmd.opcode == OP_LOAD_GAIN) && row_ok && col_ok;
    assign gain_wr_addr = GAIN_AW'(int'(cmd.row) * STATE_COUNT + int'(cmd.column));
    assign gain_rd_en   = (state_reg == ST_RUN) && issuing_reg;

    lqrsf_gain_mem #(
        .DEPTH (GAIN_DEPTH),
        .AW    (GAIN_AW)
    ) u_gain_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (gain_wr_en),
        .wr_addr (gain_wr_addr),
        .wr_data (cmd.value),
        .rd_en   (gain_rd_en),
        .rd_addr (issue_addr_reg),
        .rd_data (gain_rd_data)
    );

    // multiply stage
    assign prod_comb = gain_rd_data * diff_reg;

    // accumulate stage: floor shift, add, range check
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign sum_wide   = 64'(prod_shift) + {{32{acc_reg[s2_row_reg][31]}}, acc_reg[s2_row_reg]};
    assign sum_fits   = (&sum_wide[63:31]) || !(|sum_wide[63:31]);

    // output range check over all slots before the first result leaves
    always_comb
    begin
        logic [32:0] t;
        out_ovf = 1'b0;
        for (int r = 0; r < OUTPUT_COUNT; r++)
        begin
            t       = {trim_reg[r][31], trim_reg[r]} - {acc_reg[r][31], acc_reg[r]};
            out_ovf = out_ovf | (t[32] ^ t[31]);
        end
    end

    assign emit_bad    = bad_reg || out_ovf;
    assign torque_wide = {trim_reg[emit_row_reg][31], trim_reg[emit_row_reg]}
                       - {acc_reg[emit_row_reg][31], acc_reg[emit_row_reg]};

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (accept && (cmd.opcode == OP_STATE))
        begin
            diff_reg <= diff_wide[31:0];
        end
        if (s1_vld_reg)
        begin
            prod_reg <= prod_comb;
        end
    end

    // sequencer, tables, accumulators and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bad_reg        <= 1'b0;
            last_reg       <= 1'b0;
            issuing_reg    <= 1'b0;
            issue_row_reg  <= '0;
            issue_addr_reg <= '0;
            s1_vld_reg     <= 1'b0;
            s1_row_reg     <= '0;
            s2_vld_reg     <= 1'b0;
            s2_row_reg     <= '0;
            emit_row_reg   <= '0;
            strobe_reg     <= 1'b0;
            result_reg     <= '0;
            for (int i = 0; i < STATE_COUNT; i++)
            begin
                ref_reg[i] <= 32'sd0;
            end
            for (int i = 0; i < OUTPUT_COUNT; i++)
            begin
                trim_reg[i] <= 32'sd0;
                acc_reg[i]  <= 32'sd0;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;
            s1_vld_reg <= gain_rd_en;
            s1_row_reg <= issue_row_reg;
            s2_vld_reg <= s1_vld_reg;
            s2_row_reg <= s1_row_reg;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (cmd.opcode)
                            OP_LOAD_GAIN:
                            begin
                                // written through the gain memory port
                            end
                            OP_LOAD_REF:
                            begin
                                if (col_ok)
                                begin
                                    ref_reg[REF_AW'(cmd.column)] <= cmd.value;
                                end
                            end
                            OP_LOAD_TRIM:
                            begin
                                if (row_ok)
                                begin
                                    trim_reg[ROW_W'(cmd.row)] <= cmd.value;
                                end
                            end
                            OP_STATE:
                            begin
                                last_reg <= cmd.last;
                                if (!cmd.frame_ok || (col_ok && !diff_fits))
                                begin
                                    bad_reg <= 1'b1;
                                end
                                if (col_ok && diff_fits)
                                begin
                                    state_reg      <= ST_RUN;
                                    issuing_reg    <= 1'b1;
                                    issue_row_reg  <= '0;
                                    issue_addr_reg <= GAIN_AW'(cmd.column);
                                end
                                else if (cmd.last)
                                begin
                                    state_reg    <= ST_EMIT;
                                    emit_row_reg <= '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                ST_RUN:
                begin
                    // issue one gain row read per cycle
                    if (issuing_reg)
                    begin
                        issue_addr_reg <= issue_addr_reg + ROW_STEP;
                        if (issue_row_reg == ROW_LAST)
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_row_reg <= issue_row_reg + 1'b1;
                        end
                    end
                    // accumulate, keeping the old value on overflow
                    if (s2_vld_reg)
                    begin
                        if (sum_fits)
                        begin
                            acc_reg[s2_row_reg] <= sum_wide[31:0];
                        end
                        else
                        begin
                            bad_reg <= 1'b1;
                        end
                        if (s2_row_reg == ROW_LAST)
                        begin
                            emit_row_reg <= '0;
                            state_reg    <= last_reg ? ST_EMIT : ST_IDLE;
                        end
                    end
                end

                ST_EMIT:
                begin
                    strobe_reg           <= 1'b1;
                    result_reg.slot      <= 2'(emit_row_reg);
                    result_reg.torque    <= emit_bad ? 32'sd0 : torque_wide[31:0];
                    result_reg.valid_res <= !emit_bad;
                    result_reg.final_res <= (emit_row_reg == ROW_LAST);
                    if (emit_row_reg == ROW_LAST)
                    begin
                        // frame closed: clear for the next one
                        bad_reg   <= 1'b0;
                        state_reg <= ST_IDLE;
                        for (int i = 0; i < OUTPUT_COUNT; i++)
                        begin
                            acc_reg[i] <= 32'sd0;
                        end
                    end
                    else
                    begin
                        emit_row_reg <= emit_row_reg + 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // results only come out of the emit phase
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == ST_EMIT))
        else $error("result strobe without emit phase");

    // nothing follows the final result of a run
    a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.final_res |=> !strobe)
        else $error("result after final item");

    // an invalid result carries a zero torque
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.valid_res |-> result.torque == 32'sd0)
        else $error("invalid result with nonzero torque");

    // accumulate stage only runs inside the multiply pass
    a_acc_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> state_reg == ST_RUN)
        else $error("accumulate outside multiply pass");

    // multiply data follows a gain memory read
    a_read_before_mul: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> $past(gain_rd_en))
        else $error("multiply stage without gain read");

endmodule

// ===== dv/lqr_state_feedback_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqr_state_feedback_tb
// Self-checking bench for the state-feedback gain block. A directed table
// covers table loads, out-of-range indexes, bad frames and every overflow
// kind. It is followed by random frames of moderate coefficients with some
// scrambled and corrupted frames mixed in. Every result is compared field by
// field against an in-bench model of the control law or the table's typed values.
// ----------------------------------------------------------------------------
module lqr_state_feedback_tb;
    import lqrsf_pkg::*;

    localparam int STATES       = 10;
    localparam int OUTPUTS      = 4;
    localparam int FRAC         = 16;
    localparam int GAIN_SPAN    = 32'h0004_0000;  // +-4.0
    localparam int STATE_SPAN   = 32'h0064_0000;  // +-100.0
    localparam int RANDOM_ITEMS = 70;
    localparam int MIN_FRAMES   = 7;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    // one row of the directed table
    typedef struct {
        lqrsf_cmd_t         c;
        bit                 typed;
        logic signed [31:0] torque;
        logic               ok;
    } step_row_t;

    logic       clk    = 1'b0;
    logic       rst_n  = 1'b0;
    logic       start  = 1'b0;
    lqrsf_cmd_t cmd    = '0;
    logic       busy;
    logic       strobe;
    lqrsf_res_t result;

    // expectation typed into the table, travels with the item
    bit                 drv_typed  = 1'b0;
    logic signed [31:0] drv_torque = '0;
    logic               drv_ok     = 1'b0;

    int accepted_count = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int items_issued   = 0;
    int frames_closed  = 0;

    // control law state kept by the bench
    longint gain_q [OUTPUTS][STATES];
    longint ref_q  [STATES];
    longint trim_q [OUTPUTS];
    longint acc_q  [OUTPUTS];
    bit     frame_bad;

    lqrsf_res_t emitted [OUTPUTS];
    int         emitted_n;
    lqrsf_res_t pending_torques [$];
    step_row_t  directed_rows [$];

    lqr_state_feedback #(
        .STATE_COUNT  (STATES),
        .OUTPUT_COUNT (OUTPUTS),
        .FRAC_BITS    (FRAC)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .result (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lqr_state_feedback test failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got_v, want_v);
        error_count++;
    endtask

    function automatic bit fits32(input longint v);
        return longint'(int'(v)) == v;
    endfunction

    function automatic logic signed [31:0] small_q(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // control law: update tables or accumulators, emit on the last element
    task automatic control_law_step(input lqrsf_cmd_t c);
        longint diff;
        longint prod;
        longint sum;
        longint u;
        emitted_n = 0;
        case (c.opcode)
            OP_LOAD_GAIN:
                if (int'(c.row) < OUTPUTS && int'(c.column) < STATES)
                    gain_q[c.row][c.column] = longint'($signed(c.value));
            OP_LOAD_REF:
                if (int'(c.column) < STATES)
                    ref_q[c.column] = longint'($signed(c.value));
            OP_LOAD_TRIM:
                if (int'(c.row) < OUTPUTS)
                    trim_q[c.row] = longint'($signed(c.value));
            default:
            begin
                if (!c.frame_ok)
                    frame_bad = 1'b1;
                if (int'(c.column) < STATES)
                begin
                    diff = longint'($signed(c.value)) - ref_q[c.column];
                    if (!fits32(diff))
                        frame_bad = 1'b1;
                    else
                        for (int r = 0; r < OUTPUTS; r++)
                        begin
                            prod = gain_q[r][c.column] * diff;
                            sum  = acc_q[r] + (prod >>> FRAC);
                            if (fits32(sum))
                                acc_q[r] = sum;
                            else
                                frame_bad = 1'b1;
                        end
                end
                if (c.last)
                begin
                    for (int r = 0; r < OUTPUTS; r++)
                        if (!fits32(trim_q[r] - acc_q[r]))
                            frame_bad = 1'b1;
                    for (int r = 0; r < OUTPUTS; r++)
                    begin
                        u = trim_q[r] - acc_q[r];
                        emitted[r].slot      = 2'(r);
                        emitted[r].torque    = frame_bad ? 32'sd0 : u[31:0];
                        emitted[r].valid_res = !frame_bad;
                        emitted[r].final_res = (r == OUTPUTS - 1);
                        acc_q[r] = 0;
                    end
                    emitted_n = OUTPUTS;
                    frame_bad = 1'b0;
                end
            end
        endcase
    endtask

    // check results and predict on every accepted item
    always @(posedge clk)
    begin : monitor
        lqrsf_res_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (pending_torques.size() == 0)
                    flag_mismatch("result with nothing expected, torque", result.torque, '0);
                else
                begin
                    want = pending_torques.pop_front();
                    if (result.slot != want.slot)
                        flag_mismatch("slot", 32'(result.slot), 32'(want.slot));
                    if (result.torque != want.torque)
                        flag_mismatch("torque", result.torque, want.torque);
                    if (result.valid_res != want.valid_res)
                        flag_mismatch("valid_res", 32'(result.valid_res),
                                      32'(want.valid_res));
                    if (result.final_res != want.final_res)
                        flag_mismatch("final_res", 32'(result.final_res),
                                      32'(want.final_res));
                end
            end
            if (start && !busy)
            begin
                control_law_step(cmd);
                for (int i = 0; i < emitted_n; i++)
                begin
                    if (drv_typed)
                    begin
                        emitted[i].torque    = drv_torque;
                        emitted[i].valid_res = drv_ok;
                    end
                    pending_torques.push_back(emitted[i]);
                end
                accepted_count <= accepted_count + 1;
            end
        end
    end

    // drive one item, after a random idle gap, and wait for it to be taken
    task automatic issue(input lqrsf_cmd_t c, input int idle_pct, input bit typed,
                         input logic signed [31:0] t_torque, input logic t_ok);
        int seen;
        while (int'($urandom_range(99)) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        cmd        <= c;
        drv_typed  <= typed;
        drv_torque <= t_torque;
        drv_ok     <= t_ok;
        seen = accepted_count;
        do
            @(negedge clk);
        while (accepted_count == seen);
        items_issued++;
    endtask

    // stop sending until every expected result is back
    task automatic drain();
        start <= 1'b0;
        while (pending_torques.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_row(input lqrsf_op_t op, input int r, input int col,
                           input logic signed [31:0] v, input bit ok, input bit lst,
                           input bit typed, input logic signed [31:0] t, input bit t_ok);
        step_row_t s;
        s.c.opcode   = op;
        s.c.row      = 2'(r);
        s.c.column   = 4'(col);
        s.c.value    = v;
        s.c.frame_ok = ok;
        s.c.last     = lst;
        s.typed      = typed;
        s.torque     = t;
        s.ok         = t_ok;
        directed_rows.push_back(s);
    endtask

    // table load with a moderate value, now and then at an ignored index
    function automatic lqrsf_cmd_t random_load();
        lqrsf_cmd_t c;
        c.opcode   = lqrsf_op_t'(2'($urandom_range(2)));
        c.row      = 2'($urandom_range(3));
        c.column   = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(STATES - 1));
        c.value    = (c.opcode == OP_LOAD_GAIN) ? small_q(GAIN_SPAN) : small_q(STATE_SPAN);
        c.frame_ok = 1'($urandom_range(1));
        c.last     = 1'($urandom_range(1));
        return c;
    endfunction

    // one frame: mostly well-formed, sometimes scrambled or corrupted
    task automatic random_frame(input int idle_pct);
        lqrsf_cmd_t c;
        lqrsf_cmd_t saved;
        int         kind;
        int         len;
        kind = $urandom_range(9);
        len  = $urandom_range(1, STATES);
        repeat ($urandom_range(2))
            issue(random_load(), idle_pct, 1'b0, '0, 1'b0);
        if (kind == 0)
        begin
            // corrupted: full-range table entry and raw elements, entry reloaded with a moderate value after
            saved = random_load();
            c = saved;
            c.value = $urandom();
            issue(c, idle_pct, 1'b0, '0, 1'b0);
            for (int i = 0; i < len; i++)
            begin
                c.opcode   = OP_STATE;
                c.row      = 2'($urandom_range(3));
                c.column   = 4'($urandom_range(15));
                c.value    = $urandom();
                c.frame_ok = 1'($urandom_range(1));
                c.last     = (i == len - 1);
                issue(c, idle_pct, 1'b0, '0, 1'b0);
            end
            issue(saved, idle_pct, 1'b0, '0, 1'b0);
        end
        else
        begin
            // in order, or scattered with repeats and gaps when kind is one
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(15) == 0)
                    issue(random_load(), idle_pct, 1'b0, '0, 1'b0);
                c.opcode   = OP_STATE;
                c.row      = 2'($urandom_range(3));
                c.column   = (kind == 1) ? 4'($urandom_range(STATES - 1)) : 4'(i);
                c.value    = small_q(STATE_SPAN);
                c.frame_ok = ($urandom_range(19) != 0);
                c.last     = (i == len - 1);
                issue(c, idle_pct, 1'b0, '0, 1'b0);
            end
        end
        frames_closed++;
    endtask

    // stimulus
    initial
    begin : stimulus
        lqrsf_cmd_t c;
        int         pct_of [3];
        int         first_item;
        pct_of[0] = 0;
        pct_of[1] = 74;
        pct_of[2] = 6;
        for (int r = 0; r < OUTPUTS; r++)
        begin
            trim_q[r] = 0;
            acc_q[r]  = 0;
            for (int k = 0; k < STATES; k++)
                gain_q[r][k] = 0;
        end
        for (int k = 0; k < STATES; k++)
            ref_q[k] = 0;
        frame_bad = 1'b0;

        // directed table
        // all tables zero after reset: zero torques, valid
        add_row(OP_STATE,     0,  0, 32'sh7FFF_FFFF, 1, 1, 1, 32'sd0, 1);
        // missing frame_ok: bad frame
        add_row(OP_STATE,     2,  9, 32'sh8000_0000, 0, 1, 1, 32'sd0, 0);
        add_row(OP_LOAD_GAIN, 0,  0, 32'sh0001_0000, 0, 0, 0, '0, 0);
        add_row(OP_LOAD_GAIN, 3,  9, 32'sh8000_0000, 1, 1, 0, '0, 0);
        // gain load at an unused column is ignored
        add_row(OP_LOAD_GAIN, 1, 15, 32'sh7FFF_FFFF, 0, 0, 0, '0, 0);
        add_row(OP_LOAD_REF,  0,  0, 32'sh7FFF_FFFF, 0, 0, 0, '0, 0);
        add_row(OP_LOAD_REF,  1, 12, 32'sh1234_5678, 0, 0, 0, '0, 0);
        add_row(OP_LOAD_TRIM, 2,  0, 32'sh7FFF_FFFF, 0, 0, 0, '0, 0);
        add_row(OP_LOAD_TRIM, 0,  3, 32'sh0005_0000, 0, 0, 0, '0, 0);
        add_row(OP_STATE,     1,  0, 32'sh7FFF_FFFF, 1, 0, 0, '0, 0);
        // element at an unused column only closes the frame
        add_row(OP_STATE,     3, 10, 32'sh7FFF_FFFF, 1, 1, 0, '0, 0);
        // difference overflow
        add_row(OP_STATE,     0,  0, 32'sh8000_0000, 1, 1, 1, 32'sd0, 0);
        add_row(OP_LOAD_REF,  0,  0, 32'sd0,         0, 0, 0, '0, 0);
        // output overflow: trim minus most negative sum
        add_row(OP_STATE,     0,  9, 32'sh0001_0000, 1, 1, 1, 32'sd0, 0);
        // repeated element with a gain load in mid frame
        add_row(OP_STATE,     0,  0, 32'sh0002_0000, 1, 0, 0, '0, 0);
        add_row(OP_LOAD_GAIN, 0,  0, 32'sh0002_0000, 0, 0, 0, '0, 0);
        add_row(OP_STATE,     0,  0, 32'sh0003_0000, 1, 1, 0, '0, 0);
        // running sum overflow
        add_row(OP_LOAD_GAIN, 1,  1, 32'sh7FFF_FFFF, 0, 0, 0, '0, 0);
        add_row(OP_STATE,     0,  1, 32'sh7FFF_FFFF, 1, 1, 1, 32'sd0, 0);
        // product rounds toward minus infinity
        add_row(OP_LOAD_TRIM, 2,  0, 32'sd0,         0, 0, 0, '0, 0);
        add_row(OP_LOAD_GAIN, 2,  2, 32'sd1,         0, 0, 0, '0, 0);
        add_row(OP_STATE,     0,  2, -32'sd1,        1, 1, 0, '0, 0);
        // frame_ok missing on a non-final element only
        add_row(OP_STATE,     0, 15, 32'sd0,         0, 0, 0, '0, 0);
        add_row(OP_STATE,     0,  3, 32'sd0,         1, 1, 1, 32'sd0, 0);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].c, pct_of[2], directed_rows[i].typed,
                  directed_rows[i].torque, directed_rows[i].ok);
        drain();

        // random part: reload every table with moderate values first
        first_item = items_issued;
        for (int r = 0; r < OUTPUTS; r++)
            for (int k = 0; k < STATES; k++)
            begin
                c.opcode   = OP_LOAD_GAIN;
                c.row      = 2'(r);
                c.column   = 4'(k);
                c.value    = small_q(GAIN_SPAN);
                c.frame_ok = 1'($urandom_range(1));
                c.last     = 1'($urandom_range(1));
                issue(c, pct_of[0], 1'b0, '0, 1'b0);
            end
        for (int k = 0; k < STATES; k++)
        begin
            c.opcode = OP_LOAD_REF;
            c.column = 4'(k);
            c.value  = small_q(STATE_SPAN);
            issue(c, pct_of[0], 1'b0, '0, 1'b0);
        end
        for (int r = 0; r < OUTPUTS; r++)
        begin
            c.opcode = OP_LOAD_TRIM;
            c.row    = 2'(r);
            c.value  = small_q(STATE_SPAN);
            issue(c, pct_of[0], 1'b0, '0, 1'b0);
        end

        // frames in stretches of three per idle phase
        frames_closed = 0;
        while (items_issued - first_item < RANDOM_ITEMS || frames_closed < MIN_FRAMES)
        begin
            if (frames_closed == 5)
                drain();
            random_frame(pct_of[(frames_closed / 3) % 3]);
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("lqr_state_feedback test passed");
        else
            $display("lqr_state_feedback test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lqrsf_pkg.sv
hdl/lqrsf_gain_mem.sv
hdl/lqr_state_feedback.sv
dv/lqr_state_feedback_tb.sv
